FILE: rtl/core/mnsq_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note scale quantizer package
// Shared types, widths and constants of the note scale quantizer.
// ----------------------------------------------------------------------------
package mnsq_pkg;

	localparam int NOTE_W       = 7;
	localparam int RAND_W       = 7;
	localparam int ROOT_W       = 4;
	localparam int CHANCE_W     = 7;
	localparam int DEG_W        = 4;
	localparam int MAX_DEGREES  = 7;
	localparam int DEGREES_W    = DEG_W * MAX_DEGREES;
	localparam int OCT_W        = 4;
	localparam int CFG_DATA_W   = DEGREES_W;

	localparam logic [DEG_W-1:0]     PITCH_CLASSES = 4'd12;
	localparam logic [CHANCE_W-1:0]  FULL_CHANCE   = 7'd100;
	localparam logic [NOTE_W:0]      NOTE_MAX      = 8'd127;

	// Division of a 7-bit note by twelve as a multiply and shift.
	localparam logic [NOTE_W+5:0]    DIV12_MUL     = 13'd43;
	localparam int                   DIV12_SHIFT   = 9;

	localparam logic [ROOT_W-1:0]    ROOT_RESET    = 4'd0;
	localparam logic [CHANCE_W-1:0]  CHANCE_RESET  = 7'd100;
	localparam logic                 SCALE_RESET   = 1'b0;
	localparam logic [DEGREES_W-1:0] DEGREES_RESET = 28'hB975420;

	typedef enum logic [1:0] {
		CFG_ROOT_NOTE     = 2'd0,
		CFG_CHANCE        = 2'd1,
		CFG_SCALE_ON      = 2'd2,
		CFG_SCALE_DEGREES = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note_number;
		logic [RAND_W-1:0] random_value;
	} note_req_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note_out;
		logic              was_quantized;
	} note_res_t;

endpackage

FILE: rtl/core/midi_note_scale_quantizer_top.sv
// ----------------------------------------------------------------------------
// MIDI note scale quantizer
// Quantizes note-on numbers down onto a rotated scale, with a chance test.
// ----------------------------------------------------------------------------
// Usage:
// A request on note_valid/note_ready carries a note number and a random value
// from 0 to 99. The result channel result_valid/result_ready returns the note,
// quantized down onto the scale or passed through, and a flag that tells which.
// A quantized note that would fall below 0 or above 127 yields no result.
// The datapath is three register stages: input split and chance test, scale
// lookup, rotation and octave fix. The result is registered in the third stage,
// and one request is taken in every cycle while the result side keeps up.
// When result_ready stays low the stages fill in turn and note_ready
// falls once all three hold a request; nothing is lost or repeated.
// The configuration port writes one register per cycle with cfg_we high; the user
// must use it only while no request is in flight, as the block does not enforce it.
// Reset clears all stages and loads root 0, chance 100, scale off and the
// major scale.
// ----------------------------------------------------------------------------
module midi_note_scale_quantizer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            note_valid,
	output logic                            note_ready,
	input  mnsq_pkg::note_req_t             note_data,
	output logic                            result_valid,
	input  logic                            result_ready,
	output mnsq_pkg::note_res_t             result_data,
	input  logic                            cfg_we,
	input  mnsq_pkg::cfg_index_t            cfg_index,
	input  logic [mnsq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mnsq_pkg::*;

	logic [ROOT_W-1:0]    root_note_q;
	logic [CHANCE_W-1:0]  chance_q;
	logic                 scale_on_q;
	logic [DEGREES_W-1:0] degrees_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_note_q <= ROOT_RESET;
			chance_q    <= CHANCE_RESET;
			scale_on_q  <= SCALE_RESET;
			degrees_q   <= DEGREES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROOT_NOTE:     root_note_q <= cfg_wdata[ROOT_W-1:0];
				CFG_CHANCE:        chance_q    <= cfg_wdata[CHANCE_W-1:0];
				CFG_SCALE_ON:      scale_on_q  <= cfg_wdata[0];
				CFG_SCALE_DEGREES: degrees_q   <= cfg_wdata[DEGREES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Root reduced modulo twelve and the ascending prefix of valid degrees.
	logic [DEG_W-1:0]       root_r;
	logic [DEG_W-1:0]       deg [MAX_DEGREES];
	logic [MAX_DEGREES-1:0] deg_ok;

	always_comb begin
		root_r = (root_note_q >= PITCH_CLASSES) ? root_note_q - PITCH_CLASSES
		                                        : root_note_q;
		for (int k = 0; k < MAX_DEGREES; k++) begin
			deg[k] = degrees_q[k*DEG_W +: DEG_W];
		end
		deg_ok[0] = deg[0] < PITCH_CLASSES;
		for (int k = 1; k < MAX_DEGREES; k++) begin
			deg_ok[k] = deg_ok[k-1] && (deg[k] > deg[k-1]) && (deg[k] < PITCH_CLASSES);
		end
	end

	// Stage enables.
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	assign en3        = !v_s3 || result_ready;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign note_ready = en1;

	// Stage 1: pitch class, octave and pass-through decision.
	logic [NOTE_W+5:0] prod;
	logic [OCT_W-1:0]  oct_in;
	logic [NOTE_W-1:0] oct12_in;
	logic [DEG_W-1:0]  pc_in;
	logic              pass_in;

	always_comb begin
		prod     = {6'd0, note_data.note_number} * DIV12_MUL;
		oct_in   = prod[DIV12_SHIFT +: OCT_W];
		oct12_in = NOTE_W'({3'd0, oct_in} * 7'd12);
		pc_in    = DEG_W'(note_data.note_number - oct12_in);
		pass_in  = !scale_on_q
			|| ((chance_q != FULL_CHANCE)
				&& ((chance_q == '0) || (note_data.random_value > chance_q)));
	end

	logic [NOTE_W-1:0] note_s1;
	logic [DEG_W-1:0]  pc_s1;
	logic [OCT_W-1:0]  oct_s1;
	logic              pass_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= note_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			note_s1 <= note_data.note_number;
			pc_s1   <= pc_in;
			oct_s1  <= oct_in;
			pass_s1 <= pass_in;
		end
	end

	// Stage 2: highest valid scale degree at or below the unrotated class.
	logic [DEG_W-1:0] q_cls;
	logic [DEG_W-1:0] last;

	always_comb begin
		q_cls = (pc_s1 >= root_r) ? pc_s1 - root_r : pc_s1 + PITCH_CLASSES - root_r;
		last  = '0;
		for (int k = 0; k < MAX_DEGREES; k++) begin
			if (deg_ok[k] && (deg[k] <= q_cls)) begin
				last = deg[k];
			end
		end
	end

	logic [NOTE_W-1:0] note_s2;
	logic [DEG_W-1:0]  pc_s2;
	logic [OCT_W-1:0]  oct_s2;
	logic              pass_s2;
	logic [DEG_W-1:0]  last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			note_s2 <= note_s1;
			pc_s2   <= pc_s1;
			oct_s2  <= oct_s1;
			pass_s2 <= pass_s1;
			last_s2 <= last;
		end
	end

	// Stage 3: rotate to the root, fix the octave and check the range.
	logic [DEG_W:0]    rot_sum;
	logic [DEG_W-1:0]  mapped;
	logic              down;
	logic [OCT_W-1:0]  oct_adj;
	logic [NOTE_W:0]   res_note;
	logic              in_range;
	note_res_t         res_next;

	always_comb begin
		rot_sum  = {1'b0, last_s2} + {1'b0, root_r};
		mapped   = (rot_sum >= {1'b0, PITCH_CLASSES}) ? DEG_W'(rot_sum - {1'b0, PITCH_CLASSES})
		                                              : rot_sum[DEG_W-1:0];
		down     = mapped > pc_s2;
		oct_adj  = oct_s2 - OCT_W'(down);
		res_note = (NOTE_W+1)'({4'd0, oct_adj} * 8'd12) + {4'd0, mapped};
		in_range = !(down && (oct_s2 == '0)) && (res_note <= NOTE_MAX);
		res_next.note_out      = pass_s2 ? note_s2 : res_note[NOTE_W-1:0];
		res_next.was_quantized = !pass_s2;
	end

	note_res_t res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2 && (pass_s2 || in_range);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			res_s3 <= res_next;
		end
	end

	assign result_valid = v_s3;
	assign result_data  = res_s3;

endmodule

FILE: rtl/core/mnsq_checker.sv
// ----------------------------------------------------------------------------
// MIDI note scale quantizer checker
// Port-level assertions on the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module mnsq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                note_valid,
	input logic                note_ready,
	input mnsq_pkg::note_req_t note_data,
	input logic                result_valid,
	input logic                result_ready,
	input mnsq_pkg::note_res_t result_data,
	input logic                cfg_we
);
	import mnsq_pkg::*;

	// No result is shown while reset is held.
	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result_valid high during reset");

	// A stalled result holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("stalled result changed");

	// Requests are refused only when the result side is stalled.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!note_ready |-> result_valid && !result_ready)
		else $error("note_ready low without a stalled result");

	// A waiting request holds its value.
	a_request_hold: assert property (@(posedge clk) disable iff (!arst_n)
		note_valid && !note_ready |=> note_valid && $stable(note_data))
		else $error("waiting request changed");

	// Registers are written only while no result is pending.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !result_valid)
		else $error("register write with a result pending");

endmodule

bind midi_note_scale_quantizer_top mnsq_checker u_mnsq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.note_valid   (note_valid),
	.note_ready   (note_ready),
	.note_data    (note_data),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_data  (result_data),
	.cfg_we       (cfg_we)
);
